### rtl/core/kbd_diff_pkg.sv
// Shared types and constants for the keyboard report key-event differencer.
// No dependencies; compile first.
package kbd_diff_pkg;

  localparam int KEY_SLOTS = 6;
  localparam int MAX_SLOTS = 6;
  localparam int CODE_W    = 8;
  localparam int IDX_W     = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_REPORT  = 2'd2
  } event_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PRESS,
    S_RELEASE,
    S_REPORT
  } seq_state_t;

  typedef struct packed {
    code_t       key_slot_0;
    code_t       key_slot_1;
    code_t       key_slot_2;
    code_t       key_slot_3;
    code_t       key_slot_4;
    code_t       key_slot_5;
    logic [7:0]  modifier_bits;
  } in_item_t;

  typedef struct packed {
    event_kind_t event_kind;
    code_t       key_code;
    logic [7:0]  modifier_out;
    logic        last_event;
  } out_item_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic start;     // input transfer this cycle
    logic cur_zero;  // current slot under test is empty
    logic eq;        // shared comparator hit
    logic emit_ok;   // output register can take a result
  } seq_stat_t;

  // Sequencer commands to the datapath
  typedef struct packed {
    logic        ready;
    logic        cmp_zero;  // compare work entry against zero instead of current code
    idx_t        i;
    idx_t        j;
    logic        consume;
    logic        emit;
    event_kind_t kind;
    logic        update;
  } seq_ctrl_t;

endpackage

### rtl/core/kbd_diff_if.sv
// Valid/ready channel interfaces for the key-event differencer.
// Depends on kbd_diff_pkg for the payload types.
interface kbd_diff_in_if;
  import kbd_diff_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface kbd_diff_out_if;
  import kbd_diff_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

### rtl/core/kbd_diff_seq.sv
// Sequencer for the key-event differencer: walks slot pairs through the
// shared comparator and issues consume/emit/update commands. Uses kbd_diff_pkg.
module kbd_diff_seq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  kbd_diff_pkg::seq_stat_t stat,
  output kbd_diff_pkg::seq_ctrl_t ctrl
);
  import kbd_diff_pkg::*;

  seq_state_t state_r, state_nxt;
  idx_t       i_r, i_nxt;
  idx_t       j_r, j_nxt;
  logic       i_last, j_last;

  assign i_last = (i_r == IDX_W'(KEY_SLOTS - 1));
  assign j_last = (j_r == IDX_W'(KEY_SLOTS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  // Next state and slot counters
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    unique case (state_r)
      S_IDLE: begin
        if (stat.start) begin
          state_nxt = S_PRESS;
          i_nxt     = '0;
          j_nxt     = '0;
        end
      end
      S_PRESS: begin
        priority if (stat.cur_zero || stat.eq || (j_last && stat.emit_ok)) begin
          j_nxt = '0;
          if (i_last) begin
            state_nxt = S_RELEASE;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else if (!j_last) begin
          j_nxt = j_r + 1'b1;
        end else begin
          // hold: press pending, output register full
          j_nxt = j_r;
        end
      end
      S_RELEASE: begin
        if (stat.eq || stat.emit_ok) begin
          if (j_last) begin
            state_nxt = S_REPORT;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      S_REPORT: begin
        if (stat.emit_ok) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // Commands
  always_comb begin
    ctrl          = '0;
    ctrl.i        = i_r;
    ctrl.j        = j_r;
    ctrl.ready    = (state_r == S_IDLE);
    ctrl.cmp_zero = (state_r == S_RELEASE);
    ctrl.kind     = EV_REPORT;
    unique case (state_r)
      S_IDLE: begin
        ctrl.kind = EV_REPORT;
      end
      S_PRESS: begin
        ctrl.kind    = EV_PRESS;
        ctrl.consume = !stat.cur_zero && stat.eq;
        ctrl.emit    = !stat.cur_zero && !stat.eq && j_last && stat.emit_ok;
      end
      S_RELEASE: begin
        ctrl.kind = EV_RELEASE;
        ctrl.emit = !stat.eq && stat.emit_ok;
      end
      S_REPORT: begin
        ctrl.kind   = EV_REPORT;
        ctrl.emit   = stat.emit_ok;
        ctrl.update = stat.emit_ok;
      end
    endcase
  end

endmodule

### rtl/core/keyboard_report_key_event_diff_top.sv
// Top level of the keyboard report key-event differencer: slot registers,
// shared comparator and output register. Uses kbd_diff_pkg, kbd_diff_if, kbd_diff_seq.
//
//   Channel  Dir  Handshake         Payload
//   in_ch    in   valid/ready       six key slot codes, modifier byte
//   out_ch   out  valid/ready       event kind, key code, modifiers, last flag
//
// One 8-bit comparator is shared over all slot pairs, one compare per cycle.
// A report runs a press scan (each nonempty slot against the work copies up to
// its first match, a press when none matches), a release scan over the work
// copies, then the report event; output stalls lengthen it.
// Synchronous active-low reset clears the held codes (no keys down).
// A full output register holds the scan; in_ready is high only between reports.
module keyboard_report_key_event_diff_top (
  input  logic                  clk,
  input  logic                  rst_n,
  kbd_diff_in_if.sink           in_ch,
  kbd_diff_out_if.source        out_ch
);
  import kbd_diff_pkg::*;

  seq_stat_t  stat;
  seq_ctrl_t  ctrl;

  code_t      in_codes [MAX_SLOTS];
  code_t      cur_r    [KEY_SLOTS];
  code_t      work_r   [KEY_SLOTS];
  code_t      prev_r   [KEY_SLOTS];
  logic [7:0] mods_r;

  logic       out_valid_r;
  out_item_t  out_item_r;

  code_t      cur_sel;
  code_t      work_sel;
  code_t      cmp_a;
  code_t      emit_code;

  assign in_codes[0] = in_ch.item.key_slot_0;
  assign in_codes[1] = in_ch.item.key_slot_1;
  assign in_codes[2] = in_ch.item.key_slot_2;
  assign in_codes[3] = in_ch.item.key_slot_3;
  assign in_codes[4] = in_ch.item.key_slot_4;
  assign in_codes[5] = in_ch.item.key_slot_5;

  // Shared compare unit
  assign cur_sel  = cur_r[ctrl.i];
  assign work_sel = work_r[ctrl.j];
  assign cmp_a    = ctrl.cmp_zero ? '0 : cur_sel;

  assign stat.start    = in_ch.valid && ctrl.ready;
  assign stat.cur_zero = (cur_sel == '0);
  assign stat.eq       = (cmp_a == work_sel);
  assign stat.emit_ok  = !out_valid_r || out_ch.ready;

  kbd_diff_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  assign in_ch.ready = ctrl.ready;

  always_comb begin
    unique case (ctrl.kind)
      EV_PRESS:   emit_code = cur_sel;
      EV_RELEASE: emit_code = work_sel;
      EV_REPORT:  emit_code = '0;
      default:    emit_code = '0;
    endcase
  end

  // Working copies: load on transfer, zero an entry when a press consumes it
  always_ff @(posedge clk) begin
    if (stat.start) begin
      for (int s = 0; s < KEY_SLOTS; s++) begin
        cur_r[s]  <= in_codes[s];
        work_r[s] <= prev_r[s];
      end
      mods_r <= in_ch.item.modifier_bits;
    end else if (ctrl.consume) begin
      work_r[ctrl.j] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < KEY_SLOTS; s++) begin
        prev_r[s] <= '0;
      end
    end else if (ctrl.update) begin
      for (int s = 0; s < KEY_SLOTS; s++) begin
        prev_r[s] <= cur_r[s];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_item_r.event_kind   <= ctrl.kind;
      out_item_r.key_code     <= emit_code;
      out_item_r.modifier_out <= mods_r;
      out_item_r.last_event   <= (ctrl.kind == EV_REPORT);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.item  = out_item_r;

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the keyboard report key-event differencer.
// Uses kbd_diff_pkg and the kbd_diff_in_if / kbd_diff_out_if channels.
module testbench;
  import kbd_diff_pkg::*;

  localparam int REPORT_ITEMS = 460;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 60;
  localparam int MAX_SHOWN    = 10;

  logic clk = 1'b0;
  logic rst_n;

  kbd_diff_in_if  in_ch ();
  kbd_diff_out_if out_ch ();

  keyboard_report_key_event_diff_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_item_t  key_reports [$];
  out_item_t expected_events [$];
  code_t     held_codes [MAX_SLOTS] = '{default: '0};

  int reports_accepted = 0;
  int events_checked   = 0;
  int press_count      = 0;
  int release_count    = 0;
  int mismatches       = 0;
  int stall_cycles     = 0;

  function automatic int sender_idle_pct();
    case (reports_accepted * 3 / REPORT_ITEMS)
      0:       return 38;
      1:       return 80;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (reports_accepted * 3 / REPORT_ITEMS)
      0:       return 80;
      1:       return 38;
      default: return 0;
    endcase
  endfunction

  // Work out the events of one report and advance the held codes.
  function automatic void predict_key_events(in_item_t rep);
    code_t     cur [MAX_SLOTS];
    code_t     work [MAX_SLOTS];
    out_item_t ev;
    bit        found;
    cur = '{rep.key_slot_0, rep.key_slot_1, rep.key_slot_2,
            rep.key_slot_3, rep.key_slot_4, rep.key_slot_5};
    for (int i = KEY_SLOTS; i < MAX_SLOTS; i++) cur[i] = '0;
    work = held_codes;
    ev.modifier_out = rep.modifier_bits;
    ev.last_event   = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (cur[i] != '0) begin
        found = 1'b0;
        for (int j = 0; j < KEY_SLOTS && !found; j++) begin
          if (work[j] == cur[i]) begin
            work[j] = '0;
            found   = 1'b1;
          end
        end
        if (!found) begin
          ev.event_kind = EV_PRESS;
          ev.key_code   = cur[i];
          expected_events.push_back(ev);
          press_count++;
        end
      end
    end
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (work[j] != '0) begin
        ev.event_kind = EV_RELEASE;
        ev.key_code   = work[j];
        expected_events.push_back(ev);
        release_count++;
      end
    end
    ev.event_kind = EV_REPORT;
    ev.key_code   = '0;
    ev.last_event = 1'b1;
    expected_events.push_back(ev);
    held_codes = cur;
  endfunction

  task automatic queue_report(input code_t c0, c1, c2, c3, c4, c5,
                              input logic [7:0] mods);
    in_item_t rep;
    rep = '{c0, c1, c2, c3, c4, c5, mods};
    key_reports.push_back(rep);
  endtask

  // Small alphabet now and then so duplicates and matches show up often.
  function automatic code_t rand_code();
    if ($urandom_range(99) < 30) return code_t'($urandom_range(1, 8));
    return code_t'($urandom_range(1, 255));
  endfunction

  // Driver: hold the item until the transfer, then advance or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.item  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_key_events(in_ch.item);
        reports_accepted <= reports_accepted + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (key_reports.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
          in_ch.valid <= 1'b1;
          in_ch.item  <= key_reports.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random and check each result transfer in order.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct());
      if (out_ch.valid && out_ch.ready) begin
        events_checked <= events_checked + 1;
        if (expected_events.size() == 0) begin
          if (mismatches < MAX_SHOWN)
            $display("unexpected event: kind %0d code %02h mods %02h last %0b",
                     out_ch.item.event_kind, out_ch.item.key_code,
                     out_ch.item.modifier_out, out_ch.item.last_event);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          if (out_ch.item.event_kind   !== want.event_kind   ||
              out_ch.item.key_code     !== want.key_code     ||
              out_ch.item.modifier_out !== want.modifier_out ||
              out_ch.item.last_event   !== want.last_event) begin
            if (mismatches < MAX_SHOWN)
              $display("event %0d: expected kind %0d code %02h mods %02h last %0b, got kind %0d code %02h mods %02h last %0b",
                       events_checked, want.event_kind, want.key_code,
                       want.modifier_out, want.last_event,
                       out_ch.item.event_kind, out_ch.item.key_code,
                       out_ch.item.modifier_out, out_ch.item.last_event);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    code_t      gen_held [MAX_SLOTS];
    code_t      c [MAX_SLOTS];
    code_t      tmp;
    logic [7:0] mods;
    int         pick;
    int         k;
    int         random_items;

    rst_n        = 1'b0;

    // Directed: empty, all ones, duplicates, reorder, full replacement.
    queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    queue_report(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00);
    queue_report(8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h55);
    queue_report(8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'haa);
    queue_report(8'h40, 8'h80, 8'h55, 8'haa, 8'h01, 8'h02, 8'h0f);
    queue_report(8'h02, 8'h01, 8'haa, 8'h55, 8'h80, 8'h40, 8'hf0);
    queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'h04, 8'h04, 8'h04, 8'h00, 8'h00, 8'h00, 8'h01);
    queue_report(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02);
    queue_report(8'h04, 8'h04, 8'h00, 8'h00, 8'h00, 8'h05, 8'h04);
    queue_report(8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h08);
    queue_report(8'h77, 8'h88, 8'h99, 8'haa, 8'hbb, 8'hcc, 8'h10);
    queue_report(8'h00, 8'h77, 8'h00, 8'h88, 8'h00, 8'h99, 8'h20);
    queue_report(8'hfe, 8'hfd, 8'hfb, 8'hf7, 8'hef, 8'hdf, 8'h7f);
    queue_report(8'hbf, 8'h7f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80);
    queue_report(8'hbf, 8'h7f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h40);

    // Random: mostly keys going down and up from a held set, some noise.
    gen_held     = '{default: '0};
    random_items = REPORT_ITEMS - key_reports.size();
    for (int n = 0; n < random_items; n++) begin
      pick = $urandom_range(99);
      mods = 8'($urandom_range(255));
      if (pick < 70) begin
        for (int s = 0; s < MAX_SLOTS; s++) begin
          if (gen_held[s] != '0 && $urandom_range(99) < 25)
            gen_held[s] = '0;
          else if (gen_held[s] == '0 && $urandom_range(99) < 30)
            gen_held[s] = ($urandom_range(99) < 10) ? gen_held[$urandom_range(5)]
                                                    : rand_code();
        end
        if ($urandom_range(99) < 30) begin
          for (int s = MAX_SLOTS - 1; s > 0; s--) begin
            k           = $urandom_range(s);
            tmp         = gen_held[s];
            gen_held[s] = gen_held[k];
            gen_held[k] = tmp;
          end
        end
        c = gen_held;
      end else if (pick < 80) begin
        c = gen_held;
      end else if (pick < 90) begin
        for (int s = 0; s < MAX_SLOTS; s++) gen_held[s] = rand_code();
        c = gen_held;
      end else begin
        for (int s = 0; s < MAX_SLOTS; s++)
          c[s] = ($urandom_range(3) == 0) ? code_t'(0) : code_t'($urandom_range(255));
      end
      queue_report(c[0], c[1], c[2], c[3], c[4], c[5], mods);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Poll once a cycle until every report is sent and every event seen.
    while (key_reports.size() != 0 || in_ch.valid || expected_events.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d reports through three stall mixes, %0d events checked",
             reports_accepted, events_checked);
    $display("predicted %0d presses and %0d releases, %0d mismatches",
             press_count, release_count, mismatches);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
